>>> rtl/vas_pkg.sv
// Types and codes shared by the valve actuator supervisor.
`timescale 1ns / 1ps

package vas_pkg;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_OPEN  = 2'd1,
      REQ_CLOSE = 2'd2,
      REQ_INIT  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_UNKNOWN = 2'd0,
      ST_OPEN    = 2'd1,
      ST_CLOSED  = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   localparam int unsigned TIMEOUT_WIDTH = 8;
   localparam int unsigned PERIODS_WIDTH = 8;

   localparam logic CSR_OPEN_TIMEOUT  = 1'b0;
   localparam logic CSR_CLOSE_TIMEOUT = 1'b1;

   localparam logic [TIMEOUT_WIDTH-1:0] OPEN_TIMEOUT_RESET  = 8'd100;
   localparam logic [TIMEOUT_WIDTH-1:0] CLOSE_TIMEOUT_RESET = 8'd120;

   typedef struct packed {
      req_code_type req_type;
      logic         open_limit;
      logic         close_limit;
   } req_item_type;

   typedef struct packed {
      logic                     drive_open;
      logic                     drive_close;
      status_type               valve_state;
      logic [PERIODS_WIDTH-1:0] open_periods;
      logic [PERIODS_WIDTH-1:0] close_periods;
   } rsp_item_type;

endpackage

>>> rtl/valve_actuator_supervisor.sv
// Valve actuator supervisor top level: drive control, limit switch and timeout supervision.
`timescale 1ns / 1ps

// One item per cycle: each accepted command or timer period updates the drive, supervision
// and count registers in the cycle it is accepted, and the outputs after that update appear
// in the result register on the next cycle. A new item is taken whenever the result register
// is empty or its item is being taken in the same cycle. Counts saturate at
// 2^COUNT_WIDTH-1; the reported periods saturate at 255. The user must write timeouts via
// the csr_ port only while the block is idle; the block itself does not enforce this.
module valve_actuator_supervisor #(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  vas_pkg::req_item_type              req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output vas_pkg::rsp_item_type              rsp_item,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [vas_pkg::TIMEOUT_WIDTH-1:0]  csr_wdata
);

   localparam int unsigned CMP_WIDTH =
      (COUNT_WIDTH > vas_pkg::TIMEOUT_WIDTH) ? COUNT_WIDTH : vas_pkg::TIMEOUT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [CMP_WIDTH-1:0]   PERIODS_MAX = CMP_WIDTH'((1 << vas_pkg::PERIODS_WIDTH) - 1);

   logic [vas_pkg::TIMEOUT_WIDTH-1:0] open_timeout_ff;
   logic [vas_pkg::TIMEOUT_WIDTH-1:0] close_timeout_ff;

   // active supervision doubles as the drive level
   logic                   opening_ff, opening_in;
   logic                   closing_ff, closing_in;
   logic [COUNT_WIDTH-1:0] open_count_ff, open_count_in;
   logic [COUNT_WIDTH-1:0] close_count_ff, close_count_in;
   vas_pkg::status_type    status_ff, status_in;

   logic                   rsp_valid_ff;
   vas_pkg::rsp_item_type  rsp_item_ff, rsp_item_in;

   logic                   req_accept;
   logic [COUNT_WIDTH-1:0] open_inc, close_inc;
   logic [CMP_WIDTH-1:0]   open_ext, close_ext;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   assign open_inc  = (open_count_ff == COUNT_MAX) ? COUNT_MAX : open_count_ff + 1'b1;
   assign close_inc = (close_count_ff == COUNT_MAX) ? COUNT_MAX : close_count_ff + 1'b1;

   always_comb begin
      opening_in     = opening_ff;
      closing_in     = closing_ff;
      open_count_in  = open_count_ff;
      close_count_in = close_count_ff;
      status_in      = status_ff;
      unique case (req_item.req_type)
         vas_pkg::REQ_OPEN: begin
            opening_in    = 1'b1;
            open_count_in = '0;
            status_in     = vas_pkg::ST_UNKNOWN;
         end
         vas_pkg::REQ_CLOSE: begin
            closing_in     = 1'b1;
            close_count_in = '0;
            status_in      = vas_pkg::ST_UNKNOWN;
         end
         vas_pkg::REQ_INIT: begin
            if (req_item.open_limit) begin
               closing_in     = 1'b1;
               close_count_in = '0;
               status_in      = vas_pkg::ST_UNKNOWN;
            end else begin
               status_in = vas_pkg::ST_CLOSED;
            end
         end
         default: begin
            if (opening_ff) begin
               open_count_in = open_inc;
               if (req_item.open_limit) begin
                  opening_in = 1'b0;
                  status_in  = vas_pkg::ST_OPEN;
               end else if (CMP_WIDTH'(open_inc) > CMP_WIDTH'(open_timeout_ff)) begin
                  opening_in = 1'b0;
                  status_in  = vas_pkg::ST_UNKNOWN;
               end
            end
            // close side evaluated last so its status wins
            if (closing_ff) begin
               close_count_in = close_inc;
               if (req_item.close_limit) begin
                  closing_in = 1'b0;
                  status_in  = vas_pkg::ST_CLOSED;
               end else if (CMP_WIDTH'(close_inc) > CMP_WIDTH'(close_timeout_ff)) begin
                  closing_in = 1'b0;
                  status_in  = vas_pkg::ST_UNKNOWN;
               end
            end
         end
      endcase
   end

   always_comb begin
      open_ext  = CMP_WIDTH'(open_count_in);
      close_ext = CMP_WIDTH'(close_count_in);
      rsp_item_in.drive_open    = opening_in;
      rsp_item_in.drive_close   = closing_in;
      rsp_item_in.valve_state   = status_in;
      rsp_item_in.open_periods  = (open_ext > PERIODS_MAX) ?
         {vas_pkg::PERIODS_WIDTH{1'b1}} : open_ext[vas_pkg::PERIODS_WIDTH-1:0];
      rsp_item_in.close_periods = (close_ext > PERIODS_MAX) ?
         {vas_pkg::PERIODS_WIDTH{1'b1}} : close_ext[vas_pkg::PERIODS_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_timeout_ff  <= vas_pkg::OPEN_TIMEOUT_RESET;
         close_timeout_ff <= vas_pkg::CLOSE_TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            vas_pkg::CSR_OPEN_TIMEOUT:  open_timeout_ff  <= csr_wdata;
            vas_pkg::CSR_CLOSE_TIMEOUT: close_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opening_ff     <= 1'b0;
         closing_ff     <= 1'b0;
         open_count_ff  <= '0;
         close_count_ff <= '0;
         status_ff      <= vas_pkg::ST_UNKNOWN;
      end else if (req_accept) begin
         opening_ff     <= opening_in;
         closing_ff     <= closing_in;
         open_count_ff  <= open_count_in;
         close_count_ff <= close_count_in;
         status_ff      <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

`ifndef ASSERT_OFF
   a_open_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_item.req_type == vas_pkg::REQ_OPEN |=>
         rsp_valid && rsp_item.drive_open && rsp_item.open_periods == '0)
      else $error("open command did not start the open drive");

   a_open_limit_stops: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_item.req_type == vas_pkg::REQ_TICK && req_item.open_limit |=>
         !rsp_item.drive_open)
      else $error("open drive still on with open limit active");

   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(open_count_ff) && $stable(close_count_ff))
      else $error("count changed without an item");
`endif

endmodule
